FILE: src/rgc_pkg.sv
// Shared types, widths and constants for the readability grade counter.
// Used by every module of the block; depends on nothing else.
package rgc_pkg;

    // Width of the letter, word and sentence counters.
    localparam int CountBits = 16;
    localparam int FieldBits = 16;
    localparam int GradeBits = 22;

    // Grade arithmetic widths, derived from the counter width.
    localparam int ProdLW = CountBits + 10;  // 588 * letters
    localparam int ProdSW = CountBits + 12;  // 2960 * sentences
    localparam int ProdWW = CountBits + 11;  // 1580 * words
    localparam int DenW   = CountBits + 7;   // 100 * words
    localparam int SumW   = CountBits + 13;  // magnitude of the numerator
    localparam int DvdW   = SumW + 1;        // 2 * magnitude + denominator
    localparam int DvsW   = DenW + 1;        // 2 * denominator
    localparam int StepW  = $clog2(DvdW);

    localparam int CoefLetter   = 588;
    localparam int CoefSentence = 2960;
    localparam int CoefWord     = 1580;
    localparam int CoefDen      = 100;

    localparam int GradePosLimit = (1 << (GradeBits - 1)) - 1;
    localparam int GradeNegLimit = (1 << (GradeBits - 1));

    localparam logic [7:0] CharUpperA  = 8'h41;
    localparam logic [7:0] CharUpperZ  = 8'h5A;
    localparam logic [7:0] CharLowerA  = 8'h61;
    localparam logic [7:0] CharLowerZ  = 8'h7A;
    localparam logic [7:0] CharSpace   = 8'h20;
    localparam logic [7:0] CharTab     = 8'h09;
    localparam logic [7:0] CharPeriod  = 8'h2E;
    localparam logic [7:0] CharQuery   = 8'h3F;
    localparam logic [7:0] CharExclaim = 8'h21;

    localparam logic [1:0] BandLow  = 2'd0;
    localparam logic [1:0] BandMid  = 2'd1;
    localparam logic [1:0] BandHigh = 2'd2;

    localparam logic signed [GradeBits-1:0] GradeBottom = GradeBits'(1);
    localparam logic signed [GradeBits-1:0] GradeTop    = GradeBits'(16);

    typedef struct packed {
        logic [7:0] text_byte;
        logic       no_char;
        logic       end_of_text;
    } t_in_req;

    typedef struct packed {
        logic signed [GradeBits-1:0] grade;
        logic [1:0]                  band;
        logic [FieldBits-1:0]        letters;
        logic [FieldBits-1:0]        words;
        logic [FieldBits-1:0]        sentences;
        logic                        overflow;
    } t_out_req;

    // Counts of one finished text, handed from the front to the back.
    typedef struct packed {
        logic [CountBits-1:0] letters;
        logic [CountBits-1:0] words;
        logic [CountBits-1:0] sentences;
        logic                 overflow;
    } t_snap;

endpackage

FILE: src/rgc_front.sv
// Front end: classifies each byte and keeps the saturating counters.
// Depends on rgc_pkg; feeds finished texts into rgc_queue.
module rgc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rgc_pkg::t_in_req i_req,
    input  logic             i_q_full,
    output logic             o_full,
    output logic             o_q_push,
    output rgc_pkg::t_snap   o_q_data
);

    localparam logic [rgc_pkg::CountBits-1:0] CountMax = '1;

    logic [rgc_pkg::CountBits-1:0] r_letters, n_letters;
    logic [rgc_pkg::CountBits-1:0] r_words, n_words;
    logic [rgc_pkg::CountBits-1:0] r_sentences, n_sentences;
    logic                          r_ovf, n_ovf;
    logic                          accept;
    logic                          is_letter, is_blank, is_mark;
    logic [7:0]                    ch;

    assign ch       = i_req.text_byte;
    assign accept   = i_push && !i_q_full;
    assign o_full   = i_q_full;
    assign o_q_push = accept && i_req.end_of_text;

    always_comb begin
        is_letter = !i_req.no_char &&
                    ((ch >= rgc_pkg::CharUpperA && ch <= rgc_pkg::CharUpperZ) ||
                     (ch >= rgc_pkg::CharLowerA && ch <= rgc_pkg::CharLowerZ));
        is_blank  = !i_req.no_char &&
                    (ch == rgc_pkg::CharSpace || ch == rgc_pkg::CharTab);
        is_mark   = !i_req.no_char &&
                    (ch == rgc_pkg::CharPeriod || ch == rgc_pkg::CharQuery ||
                     ch == rgc_pkg::CharExclaim);

        n_letters   = r_letters;
        n_words     = r_words;
        n_sentences = r_sentences;
        n_ovf       = r_ovf;
        if (is_letter) begin
            if (r_letters == CountMax) n_ovf = 1'b1;
            else n_letters = r_letters + 1'b1;
        end
        if (is_blank) begin
            if (r_words == CountMax) n_ovf = 1'b1;
            else n_words = r_words + 1'b1;
        end
        if (is_mark) begin
            if (r_sentences == CountMax) n_ovf = 1'b1;
            else n_sentences = r_sentences + 1'b1;
        end
    end

    assign o_q_data.letters   = n_letters;
    assign o_q_data.words     = n_words;
    assign o_q_data.sentences = n_sentences;
    assign o_q_data.overflow  = n_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_letters   <= '0;
            r_words     <= rgc_pkg::CountBits'(1);
            r_sentences <= '0;
            r_ovf       <= 1'b0;
        end else if (accept) begin
            if (i_req.end_of_text) begin
                r_letters   <= '0;
                r_words     <= rgc_pkg::CountBits'(1);
                r_sentences <= '0;
                r_ovf       <= 1'b0;
            end else begin
                r_letters   <= n_letters;
                r_words     <= n_words;
                r_sentences <= n_sentences;
                r_ovf       <= n_ovf;
            end
        end
    end

    a_word_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_words != '0) else $error("word count dropped to zero");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |=> (r_letters == '0 && r_sentences == '0 && !r_ovf))
        else $error("counters not cleared after end of text");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |-> !i_q_full) else $error("snapshot pushed into a full queue");

endmodule

FILE: src/rgc_queue.sv
// Two-entry queue of finished text counts between front and back.
// Depends on rgc_pkg for the snapshot type.
module rgc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rgc_pkg::t_snap i_data,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output rgc_pkg::t_snap o_data
);

    rgc_pkg::t_snap r_mem [2];
    logic           r_wr_ptr, r_rd_ptr;
    logic [1:0]     r_count;
    logic           do_push, do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) r_wr_ptr <= !r_wr_ptr;
            if (do_pop)  r_rd_ptr <= !r_rd_ptr;
            if (do_push && !do_pop)      r_count <= r_count + 2'd1;
            else if (do_pop && !do_push) r_count <= r_count - 2'd1;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3) else $error("queue count out of range");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("pop from empty queue");

endmodule

FILE: src/rgc_back.sv
// Back end: turns one text's counts into the rounded grade and band.
// Depends on rgc_pkg; takes counts from rgc_queue, holds the result register.
module rgc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  rgc_pkg::t_snap    i_q_data,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output rgc_pkg::t_out_req o_res
);

    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StMul  = 3'd1;
    localparam logic [2:0] StPrep = 3'd2;
    localparam logic [2:0] StDiv  = 3'd3;
    localparam logic [2:0] StFin  = 3'd4;

    localparam logic [rgc_pkg::DvdW-1:0] PosLimit = rgc_pkg::DvdW'(rgc_pkg::GradePosLimit);
    localparam logic [rgc_pkg::DvdW-1:0] NegLimit = rgc_pkg::DvdW'(rgc_pkg::GradeNegLimit);

    logic [2:0]                  r_state;
    rgc_pkg::t_snap              r_snap;
    logic [rgc_pkg::ProdLW-1:0]  r_p_l;
    logic [rgc_pkg::ProdSW-1:0]  r_p_s;
    logic [rgc_pkg::ProdWW-1:0]  r_p_w;
    logic [rgc_pkg::DenW-1:0]    r_den;
    logic                        r_neg;
    logic [rgc_pkg::DvdW-1:0]    r_dvd;
    logic [rgc_pkg::DvsW-1:0]    r_dvs;
    logic [rgc_pkg::DvsW-1:0]    r_rem;
    logic [rgc_pkg::StepW-1:0]   r_step;
    logic                        r_out_valid;
    rgc_pkg::t_out_req           r_out;

    logic [rgc_pkg::SumW-1:0]    pos_sum, neg_sum, mag;
    logic                        is_neg;
    logic [rgc_pkg::DvsW:0]      trial;
    logic                        ge;
    logic signed [rgc_pkg::GradeBits-1:0] grade;
    logic [1:0]                  band;
    logic                        out_free;

    assign o_q_pop  = (r_state == StIdle) && !i_q_empty;
    assign o_empty  = !r_out_valid;
    assign o_res    = r_out;
    assign out_free = !r_out_valid || i_pop;

    always_comb begin
        pos_sum = rgc_pkg::SumW'(r_p_l);
        neg_sum = rgc_pkg::SumW'(r_p_s) + rgc_pkg::SumW'(r_p_w);
        is_neg  = neg_sum > pos_sum;
        mag     = is_neg ? (neg_sum - pos_sum) : (pos_sum - neg_sum);
        trial   = {r_rem, r_dvd[rgc_pkg::DvdW-1]};
        ge      = trial >= {1'b0, r_dvs};
    end

    // Sign and clamp the quotient, then sort it into a band.
    always_comb begin
        if (r_neg) begin
            if (r_dvd > NegLimit) grade = {1'b1, {(rgc_pkg::GradeBits-1){1'b0}}};
            else grade = -$signed(r_dvd[rgc_pkg::GradeBits-1:0]);
        end else begin
            if (r_dvd > PosLimit) grade = {1'b0, {(rgc_pkg::GradeBits-1){1'b1}}};
            else grade = $signed(r_dvd[rgc_pkg::GradeBits-1:0]);
        end
        if (grade < rgc_pkg::GradeBottom)   band = rgc_pkg::BandLow;
        else if (grade > rgc_pkg::GradeTop) band = rgc_pkg::BandHigh;
        else                                band = rgc_pkg::BandMid;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            StIdle: begin
                if (o_q_pop) r_snap <= i_q_data;
            end
            StMul: begin
                r_p_l <= rgc_pkg::ProdLW'(r_snap.letters) *
                         rgc_pkg::ProdLW'(rgc_pkg::CoefLetter);
                r_p_s <= rgc_pkg::ProdSW'(r_snap.sentences) *
                         rgc_pkg::ProdSW'(rgc_pkg::CoefSentence);
                r_p_w <= rgc_pkg::ProdWW'(r_snap.words) *
                         rgc_pkg::ProdWW'(rgc_pkg::CoefWord);
                r_den <= rgc_pkg::DenW'(r_snap.words) * rgc_pkg::DenW'(rgc_pkg::CoefDen);
            end
            StPrep: begin
                r_neg  <= is_neg;
                r_dvd  <= {mag, 1'b0} + rgc_pkg::DvdW'(r_den);
                r_dvs  <= {r_den, 1'b0};
                r_rem  <= '0;
                r_step <= rgc_pkg::StepW'(rgc_pkg::DvdW - 1);
            end
            StDiv: begin
                r_rem  <= ge ? rgc_pkg::DvsW'(trial - {1'b0, r_dvs}) : rgc_pkg::DvsW'(trial);
                r_dvd  <= {r_dvd[rgc_pkg::DvdW-2:0], ge};
                r_step <= r_step - 1'b1;
            end
            StFin: begin
                if (out_free) begin
                    r_out.grade     <= grade;
                    r_out.band      <= band;
                    r_out.letters   <= rgc_pkg::FieldBits'(r_snap.letters);
                    r_out.words     <= rgc_pkg::FieldBits'(r_snap.words);
                    r_out.sentences <= rgc_pkg::FieldBits'(r_snap.sentences);
                    r_out.overflow  <= r_snap.overflow;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= StIdle;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                StIdle: if (o_q_pop) r_state <= StMul;
                StMul:  r_state <= StPrep;
                StPrep: r_state <= StDiv;
                StDiv:  if (r_step == '0) r_state <= StFin;
                StFin:  if (out_free) r_state <= StIdle;
                default: r_state <= StIdle;
            endcase
            if (r_state == StFin && out_free) r_out_valid <= 1'b1;
            else if (i_pop) r_out_valid <= 1'b0;
        end
    end

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == StDiv && r_step == '0) |=> r_state == StFin)
        else $error("division did not finish after its last step");

    a_fin_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == StFin && r_out_valid && !i_pop) |=> (r_state == StFin && r_out_valid))
        else $error("finished grade lost while result register busy");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == StDiv |-> r_rem < r_dvs)
        else $error("division remainder not below divisor");

endmodule

FILE: src/readability_grade_counter.sv
// Top level of the Coleman-Liau readability grade counter.
// Depends on rgc_pkg and instantiates rgc_front, rgc_queue and rgc_back.
//
//   Channel | Handshake                     | Payload
//   --------+-------------------------------+-------------------------------
//   input   | push in, full out             | i_req  (rgc_pkg::t_in_req)
//   result  | empty out, pop in             | o_res  (rgc_pkg::t_out_req)
//
// Text bytes are taken one per cycle and the front end never stalls on its own;
// full rises only while two finished texts wait in the queue for the back end.
// The back end takes one text at a time: it pops the counts, forms the products and then
// the dividend, runs CountBits + 14 divider steps, and loads the result register,
// where it stalls while empty is low and pop is not asserted.
// Reset is synchronous and active low; it leaves zero letters, one word, zero sentences.
module readability_grade_counter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    input  rgc_pkg::t_in_req  i_req,
    output logic              full,
    output logic              empty,
    input  logic              pop,
    output rgc_pkg::t_out_req o_res
);

    // Counts of a finished text on their way from front to back.
    logic           q_push, q_full, q_empty, q_pop;
    rgc_pkg::t_snap q_wr_data, q_rd_data;

    // The front end counts letters, blanks and sentence marks, and on the
    // last byte of a text captures the final counts and clears itself.
    rgc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_req    (i_req),
        .i_q_full (q_full),
        .o_full   (full),
        .o_q_push (q_push),
        .o_q_data (q_wr_data)
    );

    // The queue lets the front keep streaming while the back divides.
    rgc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_rd_data)
    );

    // The back end forms (588L - 2960S - 1580W) / (100W), rounds half away
    // from zero, clamps to 22 bits and sorts the grade into its band.
    rgc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_rd_data),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_res     (o_res)
    );

endmodule
